// ===== sv/tts_pkg.sv =====
// Shared types, codes and default sizes of the text terminal scrollback core.
`default_nettype none

package tts_pkg;

  // Default geometry of the scrollback store and the visible window.
  localparam int unsigned TEXT_LINES_DEF   = 32;
  localparam int unsigned LINE_COLUMNS_DEF = 21;
  localparam int unsigned VIEW_ROWS_DEF    = 10;

  // Fixed field widths of the command and result transfers.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ROW_W  = 4;
  localparam int unsigned COL_W  = 5;
  localparam int unsigned LINE_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT       = 3'd0,
    CMD_VIEW_UP   = 3'd1,
    CMD_VIEW_DOWN = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_READ      = 3'd4
  } cmd_e;

  // Control characters with a meaning of their own.
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_BEL = 8'h07;
  localparam logic [CHAR_W-1:0] CHAR_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

  // What the second stage writes back to the line length store.
  typedef enum logic [1:0] {
    LEN_NONE,
    LEN_ZERO,
    LEN_MAX
  } len_op_e;

  typedef struct packed {
    len_op_e op;       // write-back kind
    logic    fresh;    // line was just opened, so its old length counts as zero
    logic    rd;       // the length of the addressed line is read
    logic    cell_rd;  // a visible cell is read
    logic    clear;    // every line length returns to zero
  } len_req_t;

  // Result fields settled when the command is taken.
  typedef struct packed {
    logic              draw_valid;
    logic [ROW_W-1:0]  draw_row;
    logic [COL_W-1:0]  draw_col;
    logic [CHAR_W-1:0] draw_char;
    logic              redraw;
    logic              bell;
    logic [LINE_W-1:0] shown_first_line;
    logic [LINE_W-1:0] write_line;
    logic [COL_W-1:0]  write_column;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/tts_ram.sv =====
// Generic simple dual-port RAM with a registered, read-first read port.
`default_nettype none

module tts_ram #(
  parameter int unsigned WIDTH = tts_pkg::CHAR_W,
  parameter int unsigned DEPTH = tts_pkg::TEXT_LINES_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tts_line_len.sv =====
// Line length store: RAM with per-line valid bits and write-back forwarding.
`default_nettype none

module tts_line_len #(
  parameter int unsigned TEXT_LINES   = tts_pkg::TEXT_LINES_DEF,
  parameter int unsigned LINE_COLUMNS = tts_pkg::LINE_COLUMNS_DEF,
  localparam int unsigned LW          = $clog2(TEXT_LINES),
  localparam int unsigned CW          = $clog2(LINE_COLUMNS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clear_i,
  input  wire logic          rd_en_i,
  input  wire logic [LW-1:0] rd_slot_i,
  input  wire logic          wr_en_i,
  input  wire logic [LW-1:0] wr_slot_i,
  input  wire logic [CW-1:0] wr_len_i,
  output logic      [CW-1:0] len_o
);

  logic [TEXT_LINES-1:0] vld_q, vld_d;
  logic                  hit_q, sel_vld_q;
  logic [CW-1:0]         fwd_q;
  logic [CW-1:0]         ram_rdata;

  tts_ram #(
    .WIDTH(CW),
    .DEPTH(TEXT_LINES)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en_i),
    .waddr_i(wr_slot_i),
    .wdata_i(wr_len_i),
    .re_i   (rd_en_i),
    .raddr_i(rd_slot_i),
    .rdata_o(ram_rdata)
  );

  // A clear is newer than any write-back still draining from the second stage.
  always_comb begin
    vld_d = vld_q;
    if (clear_i) begin
      vld_d = '0;
    end else if (wr_en_i) begin
      vld_d[wr_slot_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // The RAM returns the old entry when it is written in the cycle of the read,
  // so that write is captured alongside the read and takes its place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      sel_vld_q <= 1'b0;
    end else if (rd_en_i) begin
      hit_q     <= wr_en_i && (wr_slot_i == rd_slot_i);
      sel_vld_q <= vld_q[rd_slot_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_q <= wr_len_i;
    end
  end

  assign len_o = hit_q ? fwd_q : (sel_vld_q ? ram_rdata : '0);

endmodule

`default_nettype wire

// ===== sv/tts_cursor.sv =====
// Command decode with the cursor, window and ring base registers.
`default_nettype none

module tts_cursor #(
  parameter int unsigned TEXT_LINES   = tts_pkg::TEXT_LINES_DEF,
  parameter int unsigned LINE_COLUMNS = tts_pkg::LINE_COLUMNS_DEF,
  parameter int unsigned VIEW_ROWS    = tts_pkg::VIEW_ROWS_DEF,
  localparam int unsigned LW          = $clog2(TEXT_LINES),
  localparam int unsigned CW          = $clog2(LINE_COLUMNS + 1),
  localparam int unsigned CIW         = (LINE_COLUMNS > 1) ? $clog2(LINE_COLUMNS) : 1,
  localparam int unsigned AW          = LW + CIW
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [tts_pkg::CMD_W-1:0]   command_i,
  input  wire logic [tts_pkg::CHAR_W-1:0]  char_code_i,
  input  wire logic [tts_pkg::ROW_W-1:0]   read_row_i,
  input  wire logic [tts_pkg::COL_W-1:0]   read_col_i,
  output tts_pkg::result_t                 result_o,
  output logic                             store_we_o,
  output logic                             store_re_o,
  output logic      [AW-1:0]               store_addr_o,
  output tts_pkg::len_req_t                len_req_o,
  output logic      [LW-1:0]               len_slot_o,
  output logic      [CW-1:0]               len_col_o
);

  localparam int unsigned RW      = tts_pkg::ROW_W;
  localparam int unsigned KW      = tts_pkg::COL_W;
  localparam int unsigned NW      = tts_pkg::LINE_W;
  localparam int unsigned LGW     = ((LW > RW) ? LW : RW) + 1;
  localparam int unsigned VR_LAST = VIEW_ROWS - 1;
  localparam logic [LW-1:0] LINE_LAST = LW'(TEXT_LINES - 1);

  logic [LW-1:0]  ring_q, ring_d;
  logic [LW-1:0]  cline_q, cline_d;
  logic [CW-1:0]  ccol_q, ccol_d;
  logic [LW-1:0]  view_q, view_d;

  logic [LW-1:0]  nl_line, nl_ring, nl_slot;
  logic           nl_scroll;
  logic           wrap;
  logic [LW-1:0]  pline, pring, pslot, diff;
  logic [CW-1:0]  pcol;
  logic           follow, in_win;
  logic [LGW-1:0] logical;
  logic           read_ok;
  logic [LW-1:0]  rslot;

  // Logical line to physical slot; both operands stay below TEXT_LINES.
  function automatic logic [LW-1:0] slot_of(input logic [LW-1:0] base,
                                            input logic [LW-1:0] line);
    logic [LW:0] sum;
    sum = {1'b0, base} + {1'b0, line};
    if (sum >= (LW+1)'(TEXT_LINES)) begin
      sum = sum - (LW+1)'(TEXT_LINES);
    end
    return sum[LW-1:0];
  endfunction

  // Line feed outcome from the current cursor; on the last line the ring turns.
  always_comb begin
    if (cline_q == LINE_LAST) begin
      nl_line   = LINE_LAST;
      nl_ring   = (ring_q == LINE_LAST) ? '0 : ring_q + LW'(1);
      nl_scroll = 1'b1;
    end else begin
      nl_line   = cline_q + LW'(1);
      nl_ring   = ring_q;
      nl_scroll = 1'b0;
    end
    nl_slot = slot_of(nl_ring, nl_line);
  end

  // Placement of a printable byte, after an automatic wrap if one is due.
  always_comb begin
    wrap   = ccol_q >= CW'(LINE_COLUMNS);
    pline  = wrap ? nl_line : cline_q;
    pring  = wrap ? nl_ring : ring_q;
    pcol   = wrap ? '0 : ccol_q;
    pslot  = slot_of(pring, pline);
    follow = (32'(pline) > VR_LAST) && ((view_q != pline) || (VIEW_ROWS > 1));
    diff   = pline - view_q;
    in_win = (pline >= view_q) && (32'(diff) < VIEW_ROWS);
  end

  // Visible cell lookup.
  always_comb begin
    logical = LGW'(view_q) + LGW'(read_row_i);
    read_ok = (32'(read_row_i) < VIEW_ROWS) && (32'(logical) < TEXT_LINES)
              && (32'(read_col_i) < LINE_COLUMNS);
    rslot   = slot_of(ring_q, LW'(logical));
  end

  always_comb begin
    ring_d       = ring_q;
    cline_d      = cline_q;
    ccol_d       = ccol_q;
    view_d       = view_q;
    result_o     = '0;
    store_we_o   = 1'b0;
    store_re_o   = 1'b0;
    store_addr_o = {pslot, pcol[CIW-1:0]};
    len_req_o    = '{op: tts_pkg::LEN_NONE, fresh: 1'b0, rd: 1'b0, cell_rd: 1'b0,
                     clear: 1'b0};
    len_slot_o   = pslot;
    len_col_o    = pcol;

    unique case (tts_pkg::cmd_e'(command_i))
      tts_pkg::CMD_PUT: begin
        unique case (char_code_i)
          tts_pkg::CHAR_CR: begin
            ccol_d = '0;
          end
          tts_pkg::CHAR_LF: begin
            cline_d         = nl_line;
            ring_d          = nl_ring;
            ccol_d          = '0;
            result_o.redraw = nl_scroll;
            len_req_o.op    = tts_pkg::LEN_ZERO;
            len_slot_o      = nl_slot;
          end
          tts_pkg::CHAR_BEL: begin
            result_o.bell = 1'b1;
          end
          tts_pkg::CHAR_BS: begin
            if (ccol_q == '0 && cline_q != '0) begin
              cline_d = cline_q - LW'(1);
              ccol_d  = CW'(LINE_COLUMNS - 1);
            end else if (ccol_q != '0) begin
              ccol_d = ccol_q - CW'(1);
            end
          end
          tts_pkg::CHAR_NUL: begin
          end
          default: begin
            cline_d         = pline;
            ring_d          = pring;
            ccol_d          = pcol + CW'(1);
            result_o.redraw = wrap && nl_scroll;
            store_we_o      = 1'b1;
            len_req_o.op    = tts_pkg::LEN_MAX;
            len_req_o.fresh = wrap;
            len_req_o.rd    = 1'b1;
            if (follow) begin
              view_d          = LW'(32'(pline) - VR_LAST);
              result_o.redraw = 1'b1;
            end else if (in_win) begin
              result_o.draw_valid = 1'b1;
              result_o.draw_row   = RW'(diff);
              result_o.draw_col   = KW'(pcol);
              result_o.draw_char  = char_code_i;
            end
          end
        endcase
      end
      tts_pkg::CMD_VIEW_UP: begin
        if (view_q != '0) begin
          view_d          = view_q - LW'(1);
          result_o.redraw = 1'b1;
        end
      end
      tts_pkg::CMD_VIEW_DOWN: begin
        // Equivalent to view_top below max(cursor_line - (VIEW_ROWS-1), 0).
        if (32'(view_q) + VR_LAST < 32'(cline_q)) begin
          view_d          = view_q + LW'(1);
          result_o.redraw = 1'b1;
        end
      end
      tts_pkg::CMD_CLEAR: begin
        ring_d          = '0;
        cline_d         = '0;
        ccol_d          = '0;
        view_d          = '0;
        result_o.redraw = 1'b1;
        len_req_o.clear = 1'b1;
      end
      tts_pkg::CMD_READ: begin
        store_re_o        = read_ok;
        store_addr_o      = {rslot, CIW'(read_col_i)};
        len_req_o.rd      = read_ok;
        len_req_o.cell_rd = read_ok;
        len_slot_o        = rslot;
        len_col_o         = CW'(read_col_i);
      end
      default: begin
      end
    endcase

    result_o.shown_first_line = NW'(view_d);
    result_o.write_line       = NW'(cline_d);
    result_o.write_column     = KW'(ccol_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q  <= '0;
      cline_q <= '0;
      ccol_q  <= '0;
      view_q  <= '0;
    end else if (accept_i) begin
      ring_q  <= ring_d;
      cline_q <= cline_d;
      ccol_q  <= ccol_d;
      view_q  <= view_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/text_terminal_scrollback_core.sv =====
// Top level of the character-cell text terminal with a ring-based scrollback store.
//
// Commands arrive on the input channel (in_valid_i, in_stall_o) and every accepted
// command yields exactly one result transfer on the output channel (out_valid_o,
// out_stall_i). A transfer completes at a rising edge with valid high and stall low.
//
// The result of an accepted command is registered in stage one, then in the output
// register that drives out_valid_o. Throughput is one command per cycle while the
// receiver does not stall: the cursor, window and ring base update in the accepting
// cycle, the character store is read or written at most once per command, and the
// line length store does a read-modify-write in the second stage with forwarding of
// the previous write-back, so back-to-back characters on one line never wait.
//
// The output register decouples the sides: while a result waits on a stalled
// receiver, one more command is taken into the second stage; only when that stage
// is also full does in_stall_o rise. Results are never dropped or repeated.
//
// Reset clears the cursor, window, ring base, line lengths and both pipeline
// stages at once; no sweep is needed and a command can be taken right after reset.
`default_nettype none

module text_terminal_scrollback_core #(
  parameter int unsigned TEXT_LINES   = tts_pkg::TEXT_LINES_DEF,
  parameter int unsigned LINE_COLUMNS = tts_pkg::LINE_COLUMNS_DEF,
  parameter int unsigned VIEW_ROWS    = tts_pkg::VIEW_ROWS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tts_pkg::CMD_W-1:0]   command_i,
  input  wire logic [tts_pkg::CHAR_W-1:0]  char_code_i,
  input  wire logic [tts_pkg::ROW_W-1:0]   read_row_i,
  input  wire logic [tts_pkg::COL_W-1:0]   read_col_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             draw_valid_o,
  output logic      [tts_pkg::ROW_W-1:0]   draw_row_o,
  output logic      [tts_pkg::COL_W-1:0]   draw_col_o,
  output logic      [tts_pkg::CHAR_W-1:0]  draw_char_o,
  output logic                             redraw_o,
  output logic                             bell_o,
  output logic      [tts_pkg::CHAR_W-1:0]  cell_char_o,
  output logic      [tts_pkg::LINE_W-1:0]  shown_first_line_o,
  output logic      [tts_pkg::LINE_W-1:0]  write_line_o,
  output logic      [tts_pkg::COL_W-1:0]   write_column_o
);

  localparam int unsigned LW    = $clog2(TEXT_LINES);
  localparam int unsigned CW    = $clog2(LINE_COLUMNS + 1);
  localparam int unsigned CIW   = (LINE_COLUMNS > 1) ? $clog2(LINE_COLUMNS) : 1;
  localparam int unsigned AW    = LW + CIW;
  localparam int unsigned DEPTH = TEXT_LINES * (2 ** CIW);

  logic                  accept;
  logic                  s1_adv;

  tts_pkg::result_t      s0_res;
  tts_pkg::len_req_t     s0_req;
  logic                  st_we, st_re;
  logic [AW-1:0]         st_addr;
  logic [LW-1:0]         s0_slot;
  logic [CW-1:0]         s0_col;

  logic                  s1_valid_q;
  tts_pkg::result_t      s1_res_q;
  tts_pkg::len_req_t     s1_req_q;
  logic [LW-1:0]         s1_slot_q;
  logic [CW-1:0]         s1_col_q;

  logic [tts_pkg::CHAR_W-1:0] st_rdata;
  logic [CW-1:0]         len_rd, len_eff, len_col1, len_wr;
  logic                  len_we;
  logic [tts_pkg::CHAR_W-1:0] cell_byte;

  logic                  out_valid_q;
  tts_pkg::result_t      out_res_q;
  logic [tts_pkg::CHAR_W-1:0] out_cell_q;

  // Handshake: stage one moves on whenever the output register is free or drains.
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  tts_cursor #(
    .TEXT_LINES  (TEXT_LINES),
    .LINE_COLUMNS(LINE_COLUMNS),
    .VIEW_ROWS   (VIEW_ROWS)
  ) u_cursor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .result_o    (s0_res),
    .store_we_o  (st_we),
    .store_re_o  (st_re),
    .store_addr_o(st_addr),
    .len_req_o   (s0_req),
    .len_slot_o  (s0_slot),
    .len_col_o   (s0_col)
  );

  tts_ram #(
    .WIDTH(tts_pkg::CHAR_W),
    .DEPTH(DEPTH)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (accept && st_we),
    .waddr_i(st_addr),
    .wdata_i(char_code_i),
    .re_i   (accept && st_re),
    .raddr_i(st_addr),
    .rdata_o(st_rdata)
  );

  tts_line_len #(
    .TEXT_LINES  (TEXT_LINES),
    .LINE_COLUMNS(LINE_COLUMNS)
  ) u_line_len (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (accept && s0_req.clear),
    .rd_en_i  (accept && s0_req.rd),
    .rd_slot_i(s0_slot),
    .wr_en_i  (len_we),
    .wr_slot_i(s1_slot_q),
    .wr_len_i (len_wr),
    .len_o    (len_rd)
  );

  // Stage one: the line length arrives from the store; a freshly opened line
  // counts as empty. The write-back happens once, as the command leaves the stage.
  always_comb begin
    len_eff   = s1_req_q.fresh ? '0 : len_rd;
    len_col1  = s1_col_q + CW'(1);
    len_wr    = '0;
    if (s1_req_q.op == tts_pkg::LEN_MAX) begin
      len_wr = (len_col1 > len_eff) ? len_col1 : len_eff;
    end
    len_we    = s1_valid_q && s1_adv && (s1_req_q.op != tts_pkg::LEN_NONE);
    cell_byte = (s1_req_q.cell_rd && (s1_col_q < len_eff)) ? st_rdata : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q  <= s0_res;
      s1_req_q  <= s0_req;
      s1_slot_q <= s0_slot;
      s1_col_q  <= s0_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_res_q  <= s1_res_q;
      out_cell_q <= cell_byte;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign draw_valid_o       = out_res_q.draw_valid;
  assign draw_row_o         = out_res_q.draw_row;
  assign draw_col_o         = out_res_q.draw_col;
  assign draw_char_o        = out_res_q.draw_char;
  assign redraw_o           = out_res_q.redraw;
  assign bell_o             = out_res_q.bell;
  assign cell_char_o        = out_cell_q;
  assign shown_first_line_o = out_res_q.shown_first_line;
  assign write_line_o       = out_res_q.write_line;
  assign write_column_o     = out_res_q.write_column;

  // A command either writes or reads the character store, never both.
  a_store_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(st_we && st_re))
    else $error("character store written and read by one command");

  // A command held in stage one keeps its decoded result.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_res_q)))
    else $error("stage one lost or changed a held command");

  // A read result carries nothing of a drawing command.
  a_cell_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_cell_q != '0)) |-> (!draw_valid_o && !redraw_o && !bell_o))
    else $error("cell read mixed with draw, redraw or bell");

  // A bell neither draws nor redraws.
  a_bell_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bell_o) |-> (!draw_valid_o && !redraw_o))
    else $error("bell mixed with draw or redraw");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for text_terminal_scrollback_core: directed table, then random.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam int unsigned TEXT_LINES   = TEXT_LINES_DEF;
  localparam int unsigned LINE_COLUMNS = LINE_COLUMNS_DEF;
  localparam int unsigned VIEW_ROWS    = VIEW_ROWS_DEF;
  localparam int unsigned STORE_CELLS  = TEXT_LINES * LINE_COLUMNS;

  // Command codes that the block must pass through with positions only.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned IDLE_PCT     = 10;
  localparam int unsigned QUIET_FROM   = 700;
  localparam int unsigned QUIET_TO     = 900;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic              draw_valid;
    logic [ROW_W-1:0]  draw_row;
    logic [COL_W-1:0]  draw_col;
    logic [CHAR_W-1:0] draw_char;
    logic              redraw;
    logic              bell;
    logic [CHAR_W-1:0] cell_char;
    logic [LINE_W-1:0] shown_first_line;
    logic [LINE_W-1:0] write_line;
    logic [COL_W-1:0]  write_column;
  } screen_result_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rrow;
    logic [COL_W-1:0]  rcol;
    bit                typed;
    screen_result_t    want;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  command_i = '0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [ROW_W-1:0]  read_row_i = '0;
  logic [COL_W-1:0]  read_col_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              draw_valid_o;
  logic [ROW_W-1:0]  draw_row_o;
  logic [COL_W-1:0]  draw_col_o;
  logic [CHAR_W-1:0] draw_char_o;
  logic              redraw_o;
  logic              bell_o;
  logic [CHAR_W-1:0] cell_char_o;
  logic [LINE_W-1:0] shown_first_line_o;
  logic [LINE_W-1:0] write_line_o;
  logic [COL_W-1:0]  write_column_o;

  // Terminal state as the block should hold it.
  logic [CHAR_W-1:0] glyphs [STORE_CELLS];
  bit                glyph_written [STORE_CELLS];
  int unsigned       line_len [TEXT_LINES];
  int unsigned       scroll_base;
  int unsigned       cursor_row;
  int unsigned       cursor_column;
  int unsigned       window_top;

  screen_result_t screen_expect_q [$];
  plan_row_t      plan [$];
  int unsigned    items_sent;
  int unsigned    mismatch_count;
  int unsigned    cycle_count;

  text_terminal_scrollback_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .char_code_i        (char_code_i),
    .read_row_i         (read_row_i),
    .read_col_i         (read_col_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .draw_valid_o       (draw_valid_o),
    .draw_row_o         (draw_row_o),
    .draw_col_o         (draw_col_o),
    .draw_char_o        (draw_char_o),
    .redraw_o           (redraw_o),
    .bell_o             (bell_o),
    .cell_char_o        (cell_char_o),
    .shown_first_line_o (shown_first_line_o),
    .write_line_o       (write_line_o),
    .write_column_o     (write_column_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit quiet_stretch();
    return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
  endfunction

  function automatic int unsigned slot_of(int unsigned logical);
    return (scroll_base + logical) % TEXT_LINES;
  endfunction

  // Moves the cursor to a fresh line; tells whether the ring had to turn.
  function automatic bit open_line();
    bit turned;
    turned = 1'b0;
    if (cursor_row >= TEXT_LINES - 1) begin
      cursor_row  = TEXT_LINES - 1;
      scroll_base = (scroll_base + 1) % TEXT_LINES;
      turned      = 1'b1;
    end else begin
      cursor_row++;
    end
    line_len[slot_of(cursor_row)] = 0;
    cursor_column = 0;
    return turned;
  endfunction

  function automatic screen_result_t terminal_step(logic [CMD_W-1:0] cmd,
                                                   logic [CHAR_W-1:0] ch,
                                                   logic [ROW_W-1:0] rrow,
                                                   logic [COL_W-1:0] rcol);
    screen_result_t r;
    int unsigned    slot;
    int unsigned    logical;
    int unsigned    floor_top;
    r = '0;
    case (cmd)
      CMD_PUT: begin
        if (ch == CHAR_CR) begin
          cursor_column = 0;
        end else if (ch == CHAR_LF) begin
          r.redraw = open_line();
        end else if (ch == CHAR_BEL) begin
          r.bell = 1'b1;
        end else if (ch == CHAR_BS) begin
          if (cursor_column == 0 && cursor_row != 0) begin
            cursor_row--;
            cursor_column = LINE_COLUMNS - 1;
          end else if (cursor_column > 0) begin
            cursor_column--;
          end
        end else if (ch != CHAR_NUL) begin
          if (cursor_column >= LINE_COLUMNS) r.redraw = open_line();
          slot = slot_of(cursor_row);
          glyphs[slot * LINE_COLUMNS + cursor_column]        = ch;
          glyph_written[slot * LINE_COLUMNS + cursor_column] = 1'b1;
          if (line_len[slot] < cursor_column + 1) line_len[slot] = cursor_column + 1;
          // Past the first screenful the window is pinned to the cursor line.
          if (cursor_row > VIEW_ROWS - 1 &&
              (window_top < cursor_row || window_top + (VIEW_ROWS - 1) > cursor_row)) begin
            window_top = cursor_row - (VIEW_ROWS - 1);
            r.redraw   = 1'b1;
          end else if (cursor_row >= window_top && cursor_row - window_top < VIEW_ROWS) begin
            r.draw_valid = 1'b1;
            r.draw_row   = ROW_W'(cursor_row - window_top);
            r.draw_col   = COL_W'(cursor_column);
            r.draw_char  = ch;
          end
          cursor_column++;
        end
      end
      CMD_VIEW_UP: begin
        if (window_top > 0) begin
          window_top--;
          r.redraw = 1'b1;
        end
      end
      CMD_VIEW_DOWN: begin
        floor_top = cursor_row >= VIEW_ROWS - 1 ? cursor_row - (VIEW_ROWS - 1) : 0;
        if (window_top < floor_top) begin
          window_top++;
          r.redraw = 1'b1;
        end
      end
      CMD_CLEAR: begin
        foreach (line_len[i]) line_len[i] = 0;
        cursor_row    = 0;
        cursor_column = 0;
        window_top    = 0;
        scroll_base   = 0;
        r.redraw      = 1'b1;
      end
      CMD_READ: begin
        logical = window_top + rrow;
        if (rrow < VIEW_ROWS && logical < TEXT_LINES) begin
          slot = slot_of(logical);
          if (rcol < line_len[slot] && rcol < LINE_COLUMNS)
            r.cell_char = glyphs[slot * LINE_COLUMNS + rcol];
        end
      end
      default: ;
    endcase
    r.shown_first_line = LINE_W'(window_top);
    r.write_line       = LINE_W'(cursor_row);
    r.write_column     = COL_W'(cursor_column);
    return r;
  endfunction

  // A cell inside a line's length may never have been written (backspace to the end of
  // the line above, then a character); such a read is moved to just past the line end.
  function automatic logic [COL_W-1:0] steer_read_col(logic [ROW_W-1:0] rrow,
                                                      logic [COL_W-1:0] rcol);
    int unsigned slot;
    int unsigned logical;
    logical = window_top + rrow;
    if (rrow < VIEW_ROWS && logical < TEXT_LINES) begin
      slot = slot_of(logical);
      if (rcol < line_len[slot] && rcol < LINE_COLUMNS &&
          !glyph_written[slot * LINE_COLUMNS + rcol])
        return COL_W'(line_len[slot]);
    end
    return rcol;
  endfunction

  function automatic screen_result_t expect_fields(bit dv, int unsigned drow, int unsigned dcol,
                                                   int unsigned dchar, bit redraw, bit bell,
                                                   int unsigned cell_byte, int unsigned top,
                                                   int unsigned line, int unsigned col);
    screen_result_t r;
    r = '{dv, drow[ROW_W-1:0], dcol[COL_W-1:0], dchar[CHAR_W-1:0], redraw, bell,
          cell_byte[CHAR_W-1:0], top[LINE_W-1:0], line[LINE_W-1:0], col[COL_W-1:0]};
    return r;
  endfunction

  function automatic string show(screen_result_t r);
    return $sformatf({"draw=%0b row=%0d col=%0d char=%02h redraw=%0b bell=%0b ",
                      "cell=%02h top=%0d line=%0d column=%0d"},
                     r.draw_valid, r.draw_row, r.draw_col, r.draw_char, r.redraw, r.bell,
                     r.cell_char, r.shown_first_line, r.write_line, r.write_column);
  endfunction

  task automatic plan_row(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] rrow,
                          logic [COL_W-1:0] rcol, bit typed, screen_result_t want);
    plan.push_back('{cmd, ch, rrow, rcol, typed, want});
  endtask

  // Offers one command and returns at the edge where the transfer completes.
  task automatic issue_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                               logic [ROW_W-1:0] rrow, logic [COL_W-1:0] rcol,
                               bit typed, screen_result_t want);
    screen_result_t predicted;
    while (!quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    if (cmd == CMD_READ) rcol = steer_read_col(rrow, rcol);
    predicted = terminal_step(cmd, ch, rrow, rcol);
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    char_code_i <= ch;
    read_row_i  <= rrow;
    read_col_i  <= rcol;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    screen_expect_q.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic pick_random(output logic [CMD_W-1:0] cmd, output logic [CHAR_W-1:0] ch,
                             output logic [ROW_W-1:0] rrow, output logic [COL_W-1:0] rcol);
    int unsigned roll;
    int unsigned kind;
    roll = $urandom_range(999);
    kind = $urandom_range(99);
    ch   = CHAR_W'($urandom);
    rrow = ROW_W'($urandom_range(VIEW_ROWS - 1));
    rcol = COL_W'($urandom_range(LINE_COLUMNS - 1));
    if ($urandom_range(19) == 0) rrow = ROW_W'($urandom);
    if ($urandom_range(19) == 0) rcol = COL_W'($urandom);
    if (roll < 2) begin
      cmd = CMD_CLEAR;
    end else if (roll < 12) begin
      cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    end else if (roll < 100) begin
      cmd = CMD_VIEW_UP;
    end else if (roll < 190) begin
      cmd = CMD_VIEW_DOWN;
    end else if (roll < 400) begin
      cmd = CMD_READ;
    end else begin
      cmd = CMD_PUT;
      if (kind < 70)      ch = CHAR_W'($urandom_range(8'hFF, 8'h01));
      else if (kind < 82) ch = CHAR_LF;
      else if (kind < 88) ch = CHAR_CR;
      else if (kind < 94) ch = CHAR_BS;
      else if (kind < 97) ch = CHAR_BEL;
      else                ch = CHAR_NUL;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_terminal_scrollback_core: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off so that both pipeline stages fill.
  initial begin : receiver
    int unsigned hold_left;
    bit          held_long;
    hold_left = 0;
    held_long = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_long && items_sent >= HOLD_AT) begin
        held_long = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !quiet_stretch() && $urandom_range(99) < IDLE_PCT;
      end
    end
  end

  // Values are stable at the falling edge, so a transfer seen here completes at the next rise.
  always @(negedge clk_i) begin
    screen_result_t got;
    screen_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{draw_valid_o, draw_row_o, draw_col_o, draw_char_o, redraw_o, bell_o,
              cell_char_o, shown_first_line_o, write_line_o, write_column_o};
      if (screen_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: %s", show(got));
      end else begin
        want = screen_expect_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
      end
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rrow;
    logic [COL_W-1:0]  rcol;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // From reset: nothing stored, window and cursor at home.
    plan_row(CMD_READ,      CHAR_NUL, 0, 0, 1, expect_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan_row(CMD_VIEW_UP,   CHAR_NUL, 0, 0, 1, expect_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan_row(CMD_VIEW_DOWN, CHAR_NUL, 0, 0, 1, expect_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan_row(CMD_PUT, 8'h01,    0, 0, 1, expect_fields(1, 0, 0, 8'h01, 0, 0, 0, 0, 0, 1));
    plan_row(CMD_PUT, 8'hFF,    0, 0, 1, expect_fields(1, 0, 1, 8'hFF, 0, 0, 0, 0, 0, 2));
    plan_row(CMD_PUT, CHAR_BEL, 0, 0, 1, expect_fields(0, 0, 0, 0, 0, 1, 0, 0, 0, 2));
    plan_row(CMD_PUT, CHAR_NUL, 0, 0, 1, expect_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 2));
    plan_row(CMD_PUT, CHAR_BS,  0, 0, 1, expect_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    plan_row(CMD_PUT, CHAR_CR,  0, 0, 1, expect_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Backspace saturates on the first line.
    plan_row(CMD_PUT, CHAR_BS,  0, 0, 1, expect_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan_row(CMD_PUT, CHAR_LF,  0, 0, 1, expect_fields(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    // Backspace from column 0 lands on the last column of the line above.
    plan_row(CMD_PUT, CHAR_BS,  0, 0, 1, expect_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 20));
    plan_row(CMD_PUT, 8'h7A,    0, 0, 1, expect_fields(1, 0, 20, 8'h7A, 0, 0, 0, 0, 0, 21));
    // The next printable byte wraps onto a fresh line.
    plan_row(CMD_PUT, 8'h80,    0, 0, 1, expect_fields(1, 1, 0, 8'h80, 0, 0, 0, 0, 1, 1));
    plan_row(CMD_READ, CHAR_NUL, 0, 20, 0, '0);
    plan_row(CMD_READ, CHAR_NUL, 0, 1, 0, '0);
    plan_row(CMD_READ, CHAR_NUL, 1, 0, 0, '0);
    plan_row(CMD_READ, CHAR_NUL, 1, 1, 0, '0);
    plan_row(CMD_READ, CHAR_NUL, 4'hF, 0, 0, '0);
    plan_row(CMD_READ, CHAR_NUL, 0, 5'h1F, 0, '0);
    plan_row(CMD_SPARE_FIRST, 8'hFF, 4'hF, 5'h1F, 0, '0);
    plan_row(CMD_SPARE_FIRST + 1'b1, CHAR_LF, 0, 0, 0, '0);
    plan_row(CMD_SPARE_LAST, CHAR_CR, 0, 0, 0, '0);
    plan_row(CMD_CLEAR, CHAR_NUL, 0, 0, 1, expect_fields(0, 0, 0, 0, 1, 0, 0, 0, 0, 0));
    plan_row(CMD_VIEW_DOWN, CHAR_NUL, 0, 0, 0, '0);

    foreach (plan[i])
      issue_command(plan[i].cmd, plan[i].ch, plan[i].rrow, plan[i].rcol, plan[i].typed,
                    plan[i].want);

    repeat (RANDOM_ITEMS) begin
      pick_random(cmd, ch, rrow, rcol);
      issue_command(cmd, ch, rrow, rcol, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (screen_expect_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("text_terminal_scrollback_core: match");
    end else begin
      $display("text_terminal_scrollback_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tts_pkg.sv
sv/tts_ram.sv
sv/tts_line_len.sv
sv/tts_cursor.sv
sv/text_terminal_scrollback_core.sv
dv/tb.sv
